// File: rtl/gnso_pkg.sv
// Package: types and constants shared by the segment ordering block.
package gnso_pkg;
   localparam int MaxSegments = 64;
   localparam int CoordBits   = 24;
   localparam int IdxBits     = $clog2(MaxSegments);
   localparam int CntBits     = $clog2(MaxSegments + 1);
   localparam int DiffBits    = CoordBits + 1;
   localparam int SqBits      = 2 * CoordBits;
   localparam int DistBits    = SqBits + 1;

   typedef logic signed [CoordBits-1:0] coord_type;

   typedef struct packed {
      coord_type first_x;
      coord_type first_y;
      coord_type second_x;
      coord_type second_y;
      logic      usable;
      logic      layer_end;
   } req_type;

   typedef struct packed {
      logic [5:0] segment_index;
      coord_type  from_x;
      coord_type  from_y;
      coord_type  to_x;
      coord_type  to_y;
      logic       reversed;
      logic       jump;
      logic       run_last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;        // write req item into the store
      logic scan_start;  // clear best, begin a selection at entry 0
      logic scan_step;   // unused: never set by the controller nor read by the datapath
      logic emit;        // emit best, mark taken, move position
      logic clear_layer; // drop the layer's taken marks and count
   } gnso_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;  // last endpoint evaluated
      logic found;      // an unused endpoint exists
      logic remaining;  // another unused segment remains after this emit
   } gnso_stat_type;
endpackage

// File: rtl/gnso_datapath.sv
// Datapath: segment store, squared distance pipeline, best tracker, position.
module gnso_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  gnso_pkg::req_type      req_item,
   input  gnso_pkg::gnso_cmd_type cmd,
   output gnso_pkg::gnso_stat_type stat,
   output gnso_pkg::rsp_type      rsp_item
);
   import gnso_pkg::*;

   logic [2*CoordBits-1:0] start_mem [MaxSegments];
   logic [2*CoordBits-1:0] end_mem   [MaxSegments];
   logic [MaxSegments-1:0] taken_ff, taken_in;
   logic [CntBits-1:0]     count_ff, count_in;
   coord_type              pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic                   started_ff, started_in;

   // scan: issue pointer walks entries*2 endpoints; 4-stage pipeline
   logic [IdxBits:0]       ptr_ff, ptr_in;   // {entry, endpoint}
   logic                   issue_ff, issue_in;
   logic                   s1_v_ff, s2_v_ff, s3_v_ff;
   logic [IdxBits:0]       s1_p_ff, s2_p_ff, s3_p_ff;
   logic                   s1_tk_ff;
   logic [2*CoordBits-1:0] s1_pt_ff;
   logic [DiffBits-1:0]    s2_dx_ff, s2_dy_ff;
   logic [SqBits-1:0]      s3_qx_ff, s3_qy_ff;
   logic                   s2_tk_ff, s3_tk_ff;
   logic                   best_v_ff, best_v_in;
   logic [DistBits-1:0]    best_d_ff, best_d_in;
   logic [IdxBits:0]       best_p_ff, best_p_in;
   logic [2*CoordBits-1:0] rd_s_ff, rd_e_ff;

   logic [IdxBits-1:0]     ld_idx;
   logic                   have_room;
   logic [CntBits-1:0]     limit;
   logic [IdxBits-1:0]     ptr_ent;
   logic [DistBits-1:0]    sum_sq;
   logic [DiffBits-1:0]    ax, ay, bx, by, dx, dy;
   coord_type              fx, fy, tx, ty;
   logic [MaxSegments-1:0] taken_after;
   logic                   remaining;

   assign have_room = count_ff < CntBits'(MaxSegments);
   assign ld_idx    = count_ff[IdxBits-1:0];
   assign limit     = count_ff;
   assign ptr_ent   = ptr_ff[IdxBits:1];

   always_ff @(posedge clock) begin
      if (cmd.load && have_room) begin
         start_mem[ld_idx] <= {req_item.first_x, req_item.first_y};
         end_mem[ld_idx]   <= {req_item.second_x, req_item.second_y};
      end
      // read port: scan address while scanning, best entry otherwise
      rd_s_ff <= start_mem[issue_ff ? ptr_ent : best_p_ff[IdxBits:1]];
      rd_e_ff <= end_mem[issue_ff ? ptr_ent : best_p_ff[IdxBits:1]];
   end

   always_comb begin
      issue_in = issue_ff;
      ptr_in   = ptr_ff;
      if (cmd.scan_start) begin
         issue_in = 1'b1;
         ptr_in   = '0;
      end else if (issue_ff) begin
         ptr_in = ptr_ff + 1'b1;
         if ({1'b0, ptr_ff} == {limit, 1'b0} - 1'b1) issue_in = 1'b0;
      end
   end

   // stage 1: endpoint out of memory (select after read)
   logic                   s0_v_ff, s0_tk_ff;
   logic [IdxBits:0]       s0_p_ff;
   always_ff @(posedge clock) begin
      s0_v_ff  <= issue_ff && !reset && !cmd.scan_start;
      s0_p_ff  <= ptr_ff;
      s0_tk_ff <= taken_ff[ptr_ent];
      s1_v_ff  <= s0_v_ff;
      s1_p_ff  <= s0_p_ff;
      s1_tk_ff <= s0_tk_ff;
      s1_pt_ff <= s0_p_ff[0] ? rd_e_ff : rd_s_ff;
   end

   always_comb begin
      ax = {s1_pt_ff[2*CoordBits-1], s1_pt_ff[2*CoordBits-1:CoordBits]};
      ay = {s1_pt_ff[CoordBits-1], s1_pt_ff[CoordBits-1:0]};
      bx = {pos_x_ff[CoordBits-1], pos_x_ff};
      by = {pos_y_ff[CoordBits-1], pos_y_ff};
      dx = ($signed(ax) >= $signed(bx)) ? ax - bx : bx - ax;
      dy = ($signed(ay) >= $signed(by)) ? ay - by : by - ay;
   end

   always_ff @(posedge clock) begin
      s2_v_ff  <= s1_v_ff;
      s2_p_ff  <= s1_p_ff;
      s2_tk_ff <= s1_tk_ff;
      s2_dx_ff <= dx;
      s2_dy_ff <= dy;
      s3_v_ff  <= s2_v_ff;
      s3_p_ff  <= s2_p_ff;
      s3_tk_ff <= s2_tk_ff;
      s3_qx_ff <= SqBits'(s2_dx_ff) * SqBits'(s2_dx_ff);
      s3_qy_ff <= SqBits'(s2_dy_ff) * SqBits'(s2_dy_ff);
   end

   assign sum_sq = {1'b0, s3_qx_ff} + {1'b0, s3_qy_ff};

   // strict less keeps the earlier index and endpoint 0 on ties
   always_comb begin
      best_v_in = best_v_ff;
      best_d_in = best_d_ff;
      best_p_in = best_p_ff;
      if (cmd.scan_start) begin
         best_v_in = 1'b0;
      end else if (s3_v_ff && !s3_tk_ff && (!best_v_ff || sum_sq < best_d_ff)) begin
         best_v_in = 1'b1;
         best_d_in = sum_sq;
         best_p_in = s3_p_ff;
      end
   end

   assign stat.scan_done = s3_v_ff && ({1'b0, s3_p_ff} == {limit, 1'b0} - 1'b1);
   assign stat.found     = best_v_in;
   assign stat.remaining = remaining;

   // emit: rd_s_ff/rd_e_ff hold the best entry once the scan has drained
   always_comb begin
      fx = best_p_ff[0] ? coord_type'(rd_e_ff[2*CoordBits-1:CoordBits])
                        : coord_type'(rd_s_ff[2*CoordBits-1:CoordBits]);
      fy = best_p_ff[0] ? coord_type'(rd_e_ff[CoordBits-1:0])
                        : coord_type'(rd_s_ff[CoordBits-1:0]);
      tx = best_p_ff[0] ? coord_type'(rd_s_ff[2*CoordBits-1:CoordBits])
                        : coord_type'(rd_e_ff[2*CoordBits-1:CoordBits]);
      ty = best_p_ff[0] ? coord_type'(rd_s_ff[CoordBits-1:0])
                        : coord_type'(rd_e_ff[CoordBits-1:0]);
      taken_after = taken_ff;
      taken_after[best_p_ff[IdxBits:1]] = 1'b1;
   end

   always_comb begin
      remaining = 1'b0;
      for (int i = 0; i < MaxSegments; i++)
         if (i < int'(limit) && !taken_after[i]) remaining = 1'b1;
   end

   always_comb begin
      rsp_item.segment_index = 6'(best_p_ff[IdxBits:1]);
      rsp_item.from_x   = fx;
      rsp_item.from_y   = fy;
      rsp_item.to_x     = tx;
      rsp_item.to_y     = ty;
      rsp_item.reversed = best_p_ff[0];
      rsp_item.jump     = !started_ff || fx != pos_x_ff || fy != pos_y_ff;
      rsp_item.run_last = !remaining;
   end

   always_comb begin
      taken_in   = taken_ff;
      count_in   = count_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      started_in = started_ff;
      if (cmd.load && have_room) begin
         taken_in[ld_idx] = !req_item.usable;
         count_in         = count_ff + 1'b1;
      end
      if (cmd.emit) begin
         taken_in   = taken_after;
         pos_x_in   = tx;
         pos_y_in   = ty;
         started_in = 1'b1;
      end
      if (cmd.clear_layer) begin
         taken_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff   <= '0;
         count_ff   <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
         started_ff <= 1'b0;
         issue_ff   <= 1'b0;
         best_v_ff  <= 1'b0;
      end else begin
         taken_ff   <= taken_in;
         count_ff   <= count_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
         started_ff <= started_in;
         issue_ff   <= issue_in;
         best_v_ff  <= best_v_in;
      end
      ptr_ff    <= ptr_in;
      best_d_ff <= best_d_in;
      best_p_ff <= best_p_in;
   end
endmodule

// File: rtl/gnso_control.sv
// Controller: load, scan, fetch and emit sequencing for one layer.
module gnso_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    layer_end,
   input  gnso_pkg::gnso_stat_type stat,
   output gnso_pkg::gnso_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import gnso_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && !busy;
   assign busy   = state_ff != ST_IDLE;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      rsp_valid       = 1'b0;
      cmd.load        = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && layer_end) begin
               state_in = ST_SCAN;
               cmd.scan_start = 1'b1;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) state_in = stat.found ? ST_FETCH : ST_DONE;
         end
         // read the winning entry back
         ST_FETCH: state_in = ST_EMIT;
         ST_EMIT: begin
            cmd.emit  = 1'b1;
            rsp_valid = 1'b1;
            if (stat.remaining) begin
               state_in = ST_SCAN;
               cmd.scan_start = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.clear_layer = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule

// File: rtl/greedy_nearest_segment_order_core.sv
// Top level: greedy nearest-endpoint segment ordering core.
// Items load only while the core is idle; an item with layer_end set starts ordering and busy
// stays high until the layer is done. Each selection scans every loaded segment's two
// endpoints through one memory read port and a pipelined squared-distance unit.
// Results come one per selection on rsp_valid and cannot be stalled.
module greedy_nearest_segment_order_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gnso_pkg::req_type req_item,
   output logic              rsp_valid,
   output gnso_pkg::rsp_type rsp_item
);
   import gnso_pkg::*;

   gnso_cmd_type  cmd;
   gnso_stat_type stat;

   gnso_control u_control (
      .clock, .reset, .start,
      .layer_end(req_item.layer_end),
      .stat, .cmd, .busy, .rsp_valid
   );

   gnso_datapath u_datapath (
      .clock, .reset, .req_item, .cmd, .stat, .rsp_item
   );

`ifndef NO_ASSERTIONS
   a_no_start_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.scan_start, cmd.clear_layer, cmd.emit && !cmd.scan_start}))
      else $error("conflicting commands");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.run_last |=> !rsp_valid) else $error("result after last");
`endif
endmodule

// File: bench/tb.sv
// Testbench for the greedy nearest-endpoint segment ordering core.
module tb;
   import gnso_pkg::*;

   class order_board;
      coord_type  seg_a_x[MaxSegments], seg_a_y[MaxSegments];
      coord_type  seg_b_x[MaxSegments], seg_b_y[MaxSegments];
      bit         taken[MaxSegments];
      int         count;
      coord_type  pos_x, pos_y;
      bit         started;
      rsp_type    pending[$];
      int         mismatches;

      function new();
         count = 0; pos_x = '0; pos_y = '0; started = 0; mismatches = 0;
         foreach (taken[i]) taken[i] = 0;
      endfunction

      function longint unsigned sq_dist(coord_type x, coord_type y);
         longint dx, dy;
         dx = longint'(x) - longint'(pos_x);
         dy = longint'(y) - longint'(pos_y);
         return longint'(dx * dx) + longint'(dy * dy);
      endfunction

      function void note_item(req_type it);
         bit found, best_e;
         int best_i, first_new;
         longint unsigned best_d, d;
         rsp_type r;
         if (count < MaxSegments) begin
            seg_a_x[count] = it.first_x;  seg_a_y[count] = it.first_y;
            seg_b_x[count] = it.second_x; seg_b_y[count] = it.second_y;
            taken[count] = !it.usable;
            count++;
         end
         if (!it.layer_end) return;
         first_new = pending.size();
         forever begin
            found = 0; best_i = 0; best_e = 0; best_d = 0;
            for (int i = 0; i < count; i++) begin
               if (taken[i]) continue;
               d = sq_dist(seg_a_x[i], seg_a_y[i]);
               if (!found || d < best_d) begin
                  found = 1; best_d = d; best_i = i; best_e = 0;
               end
               d = sq_dist(seg_b_x[i], seg_b_y[i]);
               if (d < best_d) begin
                  best_d = d; best_i = i; best_e = 1;
               end
            end
            if (!found) break;
            r.segment_index = best_i[5:0];
            r.from_x = best_e ? seg_b_x[best_i] : seg_a_x[best_i];
            r.from_y = best_e ? seg_b_y[best_i] : seg_a_y[best_i];
            r.to_x = best_e ? seg_a_x[best_i] : seg_b_x[best_i];
            r.to_y = best_e ? seg_a_y[best_i] : seg_b_y[best_i];
            r.reversed = best_e;
            r.jump = !started || r.from_x != pos_x || r.from_y != pos_y;
            r.run_last = 0;
            taken[best_i] = 1;
            pos_x = r.to_x; pos_y = r.to_y; started = 1;
            pending = {pending, r};
         end
         if (pending.size() > first_new) pending[pending.size()-1].run_last = 1;
         count = 0;
         foreach (taken[i]) taken[i] = 0;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic clock, reset, start, busy, rsp_valid;
   req_type req_item;
   rsp_type rsp_item;
   order_board board;
   int cycles;
   int layers_done;
   bit calm;

   greedy_nearest_segment_order_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item));

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 4000000) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid) board.check_result(rsp_item);

   function automatic coord_type pick_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 40) - 20);
         2: return {1'b0, {(CoordBits-1){1'b1}}};
         default: return {1'b1, {(CoordBits-1){1'b0}}};
      endcase
   endfunction

   // Hold start until the item is accepted; idle at random beforehand.
   task automatic send_item(req_type it);
      while (!calm && $urandom_range(0, 99) < 29) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(it);
      if (it.layer_end) layers_done++;
   endtask

   task automatic send_seg(coord_type ax, coord_type ay, coord_type bx, coord_type by,
                           bit ok, bit last);
      req_type it;
      it.first_x = ax; it.first_y = ay; it.second_x = bx; it.second_y = by;
      it.usable = ok; it.layer_end = last;
      send_item(it);
   endtask

   task automatic random_layer(int n, int mode);
      for (int i = 0; i < n; i++)
         send_seg(pick_coord(mode), pick_coord(mode), pick_coord(mode), pick_coord(mode),
                  $urandom_range(0, 9) != 0, i == n - 1);
   endtask

   initial begin
      coord_type mx, mn;
      int sent;
      board = new();
      cycles = 0; layers_done = 0; calm = 0;
      start = 0; req_item = '0; reset = 1;
      mx = {1'b0, {(CoordBits-1){1'b1}}};
      mn = {1'b1, {(CoordBits-1){1'b0}}};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // first segment after reset jumps even from the origin
      send_seg(0, 0, 5, 5, 1, 1);
      // tie between endpoints and between segments
      send_seg(5, 6, 6, 5, 1, 0);
      send_seg(6, 5, 5, 6, 1, 0);
      send_seg(mx, mx, mn, mn, 1, 0);
      send_seg(mn, mx, mx, mn, 0, 0);
      send_seg(3, 3, 3, 3, 1, 1);
      // empty layer: only unusable segments
      send_seg(1, 1, 2, 2, 0, 0);
      send_seg(mx, mn, mn, mx, 0, 1);
      // unusable segment alone ending a layer with a usable one before it
      send_seg(mn, mn, mx, mx, 1, 0);
      send_seg(7, 7, 8, 8, 0, 1);
      // overfull layer: the dropped item still ends the layer
      for (int i = 0; i < MaxSegments + 2; i++)
         send_seg(pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0),
                  1, i == MaxSegments + 1);
      sent = 0;
      while (sent < 290) begin
         int n;
         calm = (sent > 150 && sent < 220);
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 8);
         random_layer(n, $urandom_range(0, 3) == 3 ? 3 - $urandom_range(0, 1) :
                         $urandom_range(0, 1));
         sent += n;
      end
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("ran %0d layers with ties, extremes, unusable and overfull layers",
               layers_done);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end
endmodule
